### rtl/core/udiv_pkg.sv
// Shared constants for the pipelined unsigned divider.
package udiv_pkg;

  // Default operand width; the supported range is 2 to 64 bits.
  localparam int unsigned DataWidthDef = 32;

endpackage : udiv_pkg

### rtl/core/udiv_if.sv
// Valid/ready channel interfaces for the divider operands and results.
interface udiv_in_if
  import udiv_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] dividend;
  logic [DataWidth-1:0] divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink   (input valid, dividend, divisor, output ready);
endinterface : udiv_in_if

interface udiv_out_if
  import udiv_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] quotient;
  logic [DataWidth-1:0] remainder;
  logic                 divide_by_zero;

  modport source (output valid, quotient, remainder, divide_by_zero, input ready);
  modport sink   (input valid, quotient, remainder, divide_by_zero, output ready);
endinterface : udiv_out_if

### rtl/core/unsigned_divide_with_remainder.sv
// Top level of the pipelined unsigned divider with remainder.
//
//   Channel | Direction | Beat contents                          | Handshake
//   in_i    | input     | dividend, divisor                      | valid/ready
//   out_o   | output    | quotient, remainder, divide_by_zero    | valid/ready
//
// One beat is accepted every cycle unless in_i stalls; results pass the stages,
// one quotient bit per stage, each stage one subtract and compare.
// Reset clears only the valid bits of the stages.
// Each stage holds its beat only while the stage after it is full and stalled,
// so bubbles close up and in_i stalls only when every stage is full.
module unsigned_divide_with_remainder
  import udiv_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  udiv_in_if.sink    in_i,
  udiv_out_if.source out_o
);

  logic                 valid [DataWidth+1];
  logic                 ready [DataWidth+1];
  logic [DataWidth-1:0] rem   [DataWidth+1];
  logic [DataWidth-1:0] quo   [DataWidth+1];
  logic [DataWidth-1:0] den   [DataWidth+1];
  logic                 dbz   [DataWidth+1];

  // Entry: empty partial remainder, dividend in the shifter.
  assign valid[0]   = in_i.valid;
  assign in_i.ready = ready[0];
  assign rem[0]     = '0;
  assign quo[0]     = in_i.dividend;
  assign den[0]     = in_i.divisor;
  assign dbz[0]     = (in_i.divisor == '0);

  // One stage per quotient bit, most significant first.
  for (genvar k = 0; k < DataWidth; k++) begin : g_stage
    udiv_stage #(
      .DataWidth (DataWidth)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .rem_i   (rem[k]),
      .quo_i   (quo[k]),
      .den_i   (den[k]),
      .dbz_i   (dbz[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .rem_o   (rem[k+1]),
      .quo_o   (quo[k+1]),
      .den_o   (den[k+1]),
      .dbz_o   (dbz[k+1])
    );
  end

  // Result: a zero divisor forces both results to zero.
  assign out_o.valid          = valid[DataWidth];
  assign ready[DataWidth]     = out_o.ready;
  assign out_o.quotient       = dbz[DataWidth] ? '0 : quo[DataWidth];
  assign out_o.remainder      = dbz[DataWidth] ? '0 : rem[DataWidth];
  assign out_o.divide_by_zero = dbz[DataWidth];

endmodule : unsigned_divide_with_remainder

### rtl/core/udiv_stage.sv
// One restoring-division step with its pipeline register and local flow control.
module udiv_stage
  import udiv_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Upstream side.
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [DataWidth-1:0] rem_i,
  input  logic [DataWidth-1:0] quo_i,
  input  logic [DataWidth-1:0] den_i,
  input  logic                 dbz_i,
  // Downstream side.
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [DataWidth-1:0] rem_o,
  output logic [DataWidth-1:0] quo_o,
  output logic [DataWidth-1:0] den_o,
  output logic                 dbz_o
);

  logic                 valid_q;
  logic [DataWidth-1:0] rem_d, rem_q;
  logic [DataWidth-1:0] quo_d, quo_q;
  logic [DataWidth-1:0] den_q;
  logic                 dbz_q;
  logic [DataWidth-1:0] shifted;
  logic [DataWidth-1:0] diff;
  logic                 take;

  // The quotient register doubles as the dividend shifter: its top bit is the
  // next dividend bit, and each new quotient bit enters at the bottom.
  always_comb begin
    shifted = {rem_i[DataWidth-2:0], quo_i[DataWidth-1]};
    take    = (shifted >= den_i);
    diff    = shifted - den_i;
    rem_d   = take ? diff : shifted;
    quo_d   = {quo_i[DataWidth-2:0], take};
  end

  // A stage takes a new beat when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload registers load only with a beat.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
      dbz_q <= dbz_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign dbz_o   = dbz_q;

endmodule : udiv_stage

### rtl/core/udiv_chk.sv
// Port-level checks for the divider, bound to its top level.
module udiv_chk
  import udiv_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [DataWidth-1:0] quotient_i,
  input logic [DataWidth-1:0] remainder_i,
  input logic                 divide_by_zero_i
);

  // A divide-by-zero beat carries zero results.
  a_dbz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && divide_by_zero_i |-> (quotient_i == '0) && (remainder_i == '0))
    else $error("divide-by-zero beat with nonzero results");

  // The input side stalls only when the pipeline is full behind a stalled output.
  a_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while the output side is free");

  // A stalled result beat holds.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(quotient_i)
      && $stable(remainder_i) && $stable(divide_by_zero_i))
    else $error("stalled result beat changed");

  // No result beat is shown during reset.
  a_reset_idle : assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule : udiv_chk

bind unsigned_divide_with_remainder udiv_chk #(
  .DataWidth (DataWidth)
) u_udiv_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .quotient_i       (out_o.quotient),
  .remainder_i      (out_o.remainder),
  .divide_by_zero_i (out_o.divide_by_zero)
);
